[rtl/core/vrt_pkg.sv]
package vrt_pkg;

  // Fixed-point formats
  localparam int COORD_FRAC_BITS = 8;
  localparam int DIST_WIDTH      = 32;
  localparam int DIST_FRAC_BITS  = 16;
  localparam int DIR_FRAC_BITS   = 14;
  localparam int LIMIT_FRAC_BITS = 8;

  // Field widths
  localparam int COORD_W = 24;
  localparam int DIR_W   = 16;
  localparam int CELL_W  = 16;
  localparam int MAXD_W  = 16;

  // Divider: numerator holds 2^(DIR_FRAC_BITS+DIST_FRAC_BITS), denominator a direction magnitude
  localparam int NUM_W     = DIR_FRAC_BITS + DIST_FRAC_BITS + 1;
  localparam int DEN_W     = DIR_W;
  localparam int CROSS_SHL = DIR_FRAC_BITS + DIST_FRAC_BITS - COORD_FRAC_BITS;
  localparam int EXT_W     = (NUM_W > DIST_WIDTH) ? NUM_W : DIST_WIDTH;

  // Stream payload layout
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 56;
  localparam int OFS_ORG_X  = 0;
  localparam int OFS_ORG_Y  = 24;
  localparam int OFS_ORG_Z  = 48;
  localparam int OFS_DIR_X  = 72;
  localparam int OFS_DIR_Y  = 88;
  localparam int OFS_DIR_Z  = 104;
  localparam int OFS_MAXD   = 120;
  localparam int OFS_OCC    = 136;

  typedef logic [DIST_WIDTH-1:0] dist_t;
  typedef logic [CELL_W-1:0]     cell_t;
  typedef logic [1:0]            axis_t;

  localparam dist_t DIST_MAX = '1;

  // Input op codes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_ANSWER = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_VOXEL  = 2'd0;
  localparam logic [1:0] STAT_HIT    = 2'd1;
  localparam logic [1:0] STAT_MISS   = 2'd2;
  localparam logic [1:0] STAT_NO_RAY = 2'd3;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_PICK,
    ST_STEP
  } state_t;

  // Clamp a quotient to the distance range
  function automatic dist_t sat_quo(input logic [NUM_W-1:0] q);
    logic [EXT_W-1:0] qe;
    logic [EXT_W-1:0] mx;
    begin
      qe = EXT_W'(q);
      mx = EXT_W'(DIST_MAX);
      return (qe > mx) ? DIST_MAX : DIST_WIDTH'(qe);
    end
  endfunction

endpackage

[rtl/core/vrt_div.sv]
module vrt_div import vrt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  always_comb begin
    rem_sh = {rem, acc[NUM_W-1]};
    diff   = rem_sh - {1'b0, dvs};
    ge     = (rem_sh >= {1'b0, dvs});
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and numerator/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dvs <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign quo = acc;

endmodule

[rtl/core/voxel_ray_traversal_top.sv]
// 3D voxel ray traversal (Amanatides-Woo) in fixed point. A start beat (tuser 0) carries
// origin (8 fraction bits), direction (Q2.14) and max distance; the block answers with the
// first voxel entered past the origin voxel, or a miss. The partner then answers each
// reported voxel (tuser 1) with its occupied flag, and the block returns a hit, the next
// voxel, or a miss; an answer with no ray active returns a no-ray status. Ties step on the
// later axis: x yields to y or z, and y yields to z. A start runs six passes through the
// one-bit-per-cycle restoring divider, a crossing and a delta per axis (an axis with zero
// direction skips its two passes); a step answer goes through decode, distance check, axis
// pick and step. A result held back by a stalled output waits in its state until taken.
// One beat is in flight at a time; a new beat is taken while the previous result still
// waits in the output register.
module voxel_ray_traversal_top import vrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // origin_x[23:0] origin_y[47:24] origin_z[71:48] dir_x[87:72] dir_y[103:88]
  // dir_z[119:104] max_distance[135:120] occupied[136], zero fill above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // op[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // voxel_x[15:0] voxel_y[31:16] voxel_z[47:32] normal_axis[49:48]
  // normal_negative[50], zero fill above
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [1:0]            m_tuser
);

  state_t state, state_next;

  // Latched beat
  logic [IN_DATA_W-1:0] in_data;
  logic                 in_op;

  // Traversal state
  cell_t cell_position [3];
  logic  step_negative [3];
  dist_t next_crossing [3];
  dist_t crossing_delta [3];
  dist_t travelled;
  dist_t limit;
  axis_t last_axis;
  logic  ray_active;

  // Setup sequencing
  axis_t div_axis;
  logic  div_kind;
  axis_t pick_axis;

  // Divider hookup
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] mag;

  logic                  out_free;
  logic                  emit;
  logic [1:0]            emit_user;
  logic [OUT_DATA_W-1:0] emit_data;

  logic signed [COORD_W-1:0] org [3];
  logic signed [DIR_W-1:0]   dir [3];
  logic                      occupied;

  logic [COORD_FRAC_BITS-1:0] frac;
  logic [COORD_FRAC_BITS:0]   n_dist;
  logic                       setup_last;
  dist_t                      quo_sat;

  axis_t             axis_min;
  cell_t             new_cell;
  logic [DIST_WIDTH:0] cross_sum;
  dist_t             cross_new;
  cell_t             cells_out [3];

  // Field views of the latched beat
  assign org[0]   = in_data[OFS_ORG_X +: COORD_W];
  assign org[1]   = in_data[OFS_ORG_Y +: COORD_W];
  assign org[2]   = in_data[OFS_ORG_Z +: COORD_W];
  assign dir[0]   = in_data[OFS_DIR_X +: DIR_W];
  assign dir[1]   = in_data[OFS_DIR_Y +: DIR_W];
  assign dir[2]   = in_data[OFS_DIR_Z +: DIR_W];
  assign occupied = in_data[OFS_OCC];

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Divider operands for the axis being set up
  always_comb begin
    frac    = org[div_axis][COORD_FRAC_BITS-1:0];
    mag     = dir[div_axis][DIR_W-1] ? DEN_W'(-dir[div_axis]) : DEN_W'(dir[div_axis]);
    n_dist  = dir[div_axis][DIR_W-1] ? {1'b0, frac}
                                     : ((COORD_FRAC_BITS+1)'(1) << COORD_FRAC_BITS) -
                                       {1'b0, frac};
    div_num = (div_kind == 1'b0) ? (NUM_W'(n_dist) << CROSS_SHL)
                                 : (NUM_W'(1) << (NUM_W - 1));
    quo_sat = sat_quo(div_quo);
    setup_last = div_kind && (div_axis == AXIS_Z);
  end

  // Smallest next crossing; ties go to the later axis (y over x, z over x or y)
  always_comb begin
    if (next_crossing[0] < next_crossing[1] && next_crossing[0] < next_crossing[2]) begin
      axis_min = AXIS_X;
    end else if (next_crossing[1] < next_crossing[2]) begin
      axis_min = AXIS_Y;
    end else begin
      axis_min = AXIS_Z;
    end
  end

  // Step on the picked axis
  always_comb begin
    new_cell  = step_negative[pick_axis] ? cell_position[pick_axis] - 1'b1
                                         : cell_position[pick_axis] + 1'b1;
    cross_sum = {1'b0, next_crossing[pick_axis]} + {1'b0, crossing_delta[pick_axis]};
    cross_new = cross_sum[DIST_WIDTH] ? DIST_MAX : cross_sum[DIST_WIDTH-1:0];
    for (int i = 0; i < 3; i++) begin
      cells_out[i] = (axis_t'(i) == pick_axis) ? new_cell : cell_position[i];
    end
  end

  vrt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (mag),
    .done  (div_done),
    .quo   (div_quo)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and result formation
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    emit       = 1'b0;
    emit_user  = STAT_VOXEL;
    emit_data  = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (in_op == OP_START) begin
          state_next = ST_DIV_START;
        end else if (!ray_active) begin
          emit_user = STAT_NO_RAY;
          if (out_free) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (occupied) begin
          emit_user = STAT_HIT;
          emit_data = OUT_DATA_W'({!step_negative[last_axis], last_axis,
                                   cell_position[2], cell_position[1], cell_position[0]});
          if (out_free) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_DIV_START: begin
        if (mag == '0) begin
          state_next = setup_last ? ST_CHECK : ST_DIV_START;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = setup_last ? ST_CHECK : ST_DIV_START;
      end
      ST_CHECK: begin
        if (travelled < limit) begin
          state_next = ST_PICK;
        end else begin
          emit_user = STAT_MISS;
          if (out_free) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_PICK: begin
        state_next = ST_STEP;
      end
      ST_STEP: begin
        emit_user = STAT_VOXEL;
        emit_data = OUT_DATA_W'({!step_negative[pick_axis], pick_axis,
                                 cells_out[2], cells_out[1], cells_out[0]});
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Ray-active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_active <= 1'b0;
    end else if (state == ST_DECODE && in_op == OP_START) begin
      ray_active <= 1'b1;
    end else if (emit && (emit_user == STAT_HIT || emit_user == STAT_MISS)) begin
      ray_active <= 1'b0;
    end
  end

  // Beat capture, ray setup and stepping
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      in_data <= s_tdata;
      in_op   <= s_tuser;
    end
    if (state == ST_DECODE && in_op == OP_START) begin
      for (int i = 0; i < 3; i++) begin
        cell_position[i] <= CELL_W'(org[i] >>> COORD_FRAC_BITS);
        step_negative[i] <= dir[i][DIR_W-1];
      end
      travelled <= '0;
      limit     <= DIST_WIDTH'({in_data[OFS_MAXD +: MAXD_W],
                                {(DIST_FRAC_BITS-LIMIT_FRAC_BITS){1'b0}}});
      last_axis <= AXIS_X;
      div_axis  <= AXIS_X;
      div_kind  <= 1'b0;
    end
    // Store a crossing or delta and move to the next setup pass
    if ((state == ST_DIV_START && mag == '0) || (state == ST_DIV_WAIT && div_done)) begin
      if (div_kind == 1'b0) begin
        next_crossing[div_axis] <= (mag == '0) ? DIST_MAX : quo_sat;
      end else begin
        crossing_delta[div_axis] <= (mag == '0) ? DIST_MAX : quo_sat;
      end
      div_kind <= !div_kind;
      if (div_kind) div_axis <= div_axis + 1'b1;
    end
    if (state == ST_PICK) begin
      pick_axis <= axis_min;
    end
    if (state == ST_STEP && out_free) begin
      cell_position[pick_axis] <= new_cell;
      travelled                <= next_crossing[pick_axis];
      next_crossing[pick_axis] <= cross_new;
      last_axis                <= pick_axis;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_data;
      m_tuser <= emit_user;
    end
  end

`ifndef SYNTHESIS
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_step_keeps_ray: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP && out_free) |=> (ray_active && m_tvalid && m_tuser == STAT_VOXEL))
    else $error("voxel step did not leave an active ray and a voxel result");

  a_no_ray_status: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_user == STAT_NO_RAY) |-> !ray_active)
    else $error("no-ray status issued with a ray active");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result loaded over an untaken result");
`endif

endmodule
